// ===== design/wsea_pkg.sv =====
// ----------------------------------------------------------------------------
// wsea_pkg
// Shared types, constants and helper functions for the weighted sphere error
// accumulator: payload structs, controller/datapath command and status,
// projection codes and the Q30 cosine coefficients.
// ----------------------------------------------------------------------------
package wsea_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int COL_W     = 13;
    localparam int ROW_W     = 12;
    localparam int PLANE_W   = 2;
    localparam int ERR_W     = 62;
    localparam int WSUM_W    = 40;
    localparam int FMT_W     = 3;
    localparam int FW_W      = 14;
    localparam int FH_W      = 13;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CRD_W     = 14;
    localparam int CNT_W     = 5;

    localparam logic [FW_W-1:0] MAX_WIDTH  = 14'd8192;
    localparam logic [FH_W-1:0] MAX_HEIGHT = 13'd4096;

    localparam logic [FMT_W-1:0] FMT_ERP     = 3'd0;
    localparam logic [FMT_W-1:0] FMT_CMP_3X2 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_CMP_2X3 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_CMP_6X1 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_CMP_1X6 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_CMP_T   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [FMT_W-1:0] RST_FORMAT = 3'd0;
    localparam logic [FW_W-1:0]  RST_WIDTH  = 14'd1920;
    localparam logic [FH_W-1:0]  RST_HEIGHT = 13'd1080;

    localparam logic [CNT_W-1:0] STEP_LAST  = 5'd30;
    localparam logic [CNT_W-1:0] POLY_STEPS = 5'd5;

    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic [30:0] COS_C1  = 31'd1324675879;
    localparam logic [30:0] COS_C2  = 31'd272375560;
    localparam logic [30:0] COS_C3  = 31'd22401992;
    localparam logic [30:0] COS_C4  = 31'd987048;
    localparam logic [30:0] COS_C5  = 31'd27061;
    localparam logic [30:0] COS_C6  = 31'd506;

    typedef struct packed {
        logic [SAMPLE_W-1:0] orig_sample;
        logic [SAMPLE_W-1:0] recon_sample;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [PLANE_W-1:0]  plane;
        logic                last_of_plane;
    } t_in_item;

    typedef struct packed {
        logic [ERR_W-1:0]   weighted_sq_error_sum;
        logic [WSUM_W-1:0]  weight_sum;
        logic [PLANE_W-1:0] done_plane;
    } t_out_item;

    typedef enum logic [2:0] {
        DIV_BY2,
        DIV_BY4,
        DIV_BY6,
        DIV_BY8,
        DIV_BY12
    } t_div_sel;

    typedef enum logic [2:0] {
        MUL_UU,
        MUL_ZT,
        MUL_XS,
        MUL_DD,
        MUL_PW
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     face;
        logic     center;
        logic     square;
        logic     div_load;
        logic     div_step;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     z_set;
        logic     poly_add;
        logic     w_cube;
        logic     w_zero;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic erp;
        logic zero;
        logic step_last;
        logic poly_done;
        logic last;
        logic out_free;
    } t_status;

    // floor(n / 3), exact for n below 49152 (the result is 14 bits wide)
    function automatic logic [CRD_W-1:0] div3(input logic [16:0] n);
        logic [36:0] p;
        p = {20'b0, n} * 37'd349526;
        return p[33:20];
    endfunction

    // floor(k * v / m)
    function automatic logic [CRD_W-1:0] scale_div(input logic [3:0] k,
                                                   input logic [CRD_W-1:0] v,
                                                   input t_div_sel m);
        logic [17:0]      n;
        logic [CRD_W-1:0] q;
        n = {14'b0, k} * {4'b0, v};
        unique case (m)
            DIV_BY2:  q = n[14:1];
            DIV_BY4:  q = n[15:2];
            DIV_BY8:  q = n[16:3];
            DIV_BY6:  q = div3(n[17:1]);
            DIV_BY12: q = div3({1'b0, n[17:2]});
            default:  q = '0;
        endcase
        return q;
    endfunction

    function automatic logic [30:0] cos_coef(input logic [2:0] k);
        logic [30:0] c;
        unique case (k)
            3'd0:    c = COS_C5;
            3'd1:    c = COS_C4;
            3'd2:    c = COS_C3;
            3'd3:    c = COS_C2;
            3'd4:    c = COS_C1;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/weighted_sphere_error_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_sphere_error_accumulator_unit
// Spherically weighted squared error accumulator for 360 degree video.
//
// Input channel (valid/ready) carries one original/reconstructed sample pair
// with its column, row and plane. Each sample gets a Q-format weight from the
// selected projection (equirectangular cosine or cube face distance) and adds
// weight times squared difference and the weight to two saturating sums.
// The sample flagged last_of_plane also hands both sums plus the plane code
// to the output register and clears the sums.
// One sample at a time: ready is high only while the sequencer is idle.
// A zero-weight sample skips the 31-step divider; an equirectangular one
// adds the cosine polynomial after it, a cube one the 31-step square root.
// Results sit in an output register, so a stalled receiver holds only a
// sample that closes a plane while the previous result waits.
// Configuration writes take effect at once and are meant for idle periods.
// Reset restores equirectangular 1920x1080, clears the sums and drops
// output valid.
// ----------------------------------------------------------------------------
module weighted_sphere_error_accumulator_unit #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wsea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wsea_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  wsea_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output wsea_pkg::t_out_item            o_out_item
);
    import wsea_pkg::*;

    t_cmd    cmd;
    t_status status;

    wsea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wsea_datapath #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== design/wsea_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsea_ctrl
// Sequencer for one sample: face select, centre, distances, shared divider,
// then either the cosine polynomial or the square root (a zero-weight sample
// skips all three), then error multiply, accumulate and, for a sample that
// closes a plane, result hand-off.
module wsea_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wsea_pkg::t_status i_status,
    output wsea_pkg::t_cmd    o_cmd
);
    import wsea_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_FACE   = 18'h00002,
        S_CENTER = 18'h00004,
        S_SQ     = 18'h00008,
        S_PREP   = 18'h00010,
        S_DIV    = 18'h00020,
        S_UU     = 18'h00040,
        S_ZSET   = 18'h00080,
        S_PMUL   = 18'h00100,
        S_PADD   = 18'h00200,
        S_SQLD   = 18'h00400,
        S_SQRT   = 18'h00800,
        S_XS     = 18'h01000,
        S_WSET   = 18'h02000,
        S_DMUL   = 18'h04000,
        S_EMUL   = 18'h08000,
        S_ACC    = 18'h10000,
        S_EMIT   = 18'h20000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_UU;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_FACE;
                end
            end
            S_FACE: begin
                o_cmd.face = 1'b1;
                n_state    = S_CENTER;
            end
            S_CENTER: begin
                o_cmd.center = 1'b1;
                n_state      = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                if (i_status.zero) begin
                    o_cmd.w_zero = 1'b1;
                    n_state      = S_DMUL;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.step_last) begin
                    n_state = i_status.erp ? S_UU : S_SQLD;
                end
            end
            S_UU: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_UU;
                n_state       = S_ZSET;
            end
            S_ZSET: begin
                o_cmd.z_set = 1'b1;
                n_state     = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ZT;
                n_state       = S_PADD;
            end
            S_PADD: begin
                o_cmd.poly_add = 1'b1;
                n_state        = i_status.poly_done ? S_DMUL : S_PMUL;
            end
            S_SQLD: begin
                o_cmd.sqrt_load = 1'b1;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.step_last) begin
                    n_state = S_XS;
                end
            end
            S_XS: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_XS;
                n_state       = S_WSET;
            end
            S_WSET: begin
                o_cmd.w_cube = 1'b1;
                n_state      = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DD;
                n_state       = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PW;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_FACE))
        else $error("accepted transfer did not start processing");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result loaded over an untaken result");

endmodule

// ===== design/wsea_datapath.sv =====
// ----------------------------------------------------------------------------
// wsea_datapath
// Configuration registers, face and centre logic, shared multiplier,
// restoring divider, digit-by-digit square root, accumulators and the
// output register.
// ----------------------------------------------------------------------------
module wsea_datapath #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wsea_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wsea_pkg::CFG_W-1:0]          i_cfg_data,
    input  wsea_pkg::t_in_item                  i_in_item,
    input  wsea_pkg::t_cmd                      i_cmd,
    output wsea_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wsea_pkg::t_out_item                 o_out_item
);
    import wsea_pkg::*;

    localparam int WW = WEIGHT_FRAC_BITS + 1;
    localparam logic [WW-1:0] W_ONE = WW'(1) << WEIGHT_FRAC_BITS;

    logic [FMT_W-1:0]  r_format;
    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    t_in_item          r_in;

    logic [3:0]        r_ci_k, r_cj_k;
    t_div_sel          r_ci_m, r_cj_m, r_r_m;
    logic              r_r_h, r_blank;
    logic [CRD_W-1:0]  r_ci, r_cj, r_rad, r_a;
    logic [29:0]       r_di2, r_dj2;
    logic [27:0]       r_rr;
    logic              r_zero;

    logic [31:0]       r_rem, r_div;
    logic [30:0]       r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic [60:0]       r_sv, r_sbit;
    logic [61:0]       r_sres;
    logic [63:0]       r_prod;
    logic [29:0]       r_z;
    logic [30:0]       r_t;
    logic [WW-1:0]     r_weight;

    logic [ERR_W-1:0]  r_err;
    logic [WSUM_W-1:0] r_wacc;
    logic              r_out_valid;
    t_out_item         r_out;

    // plane size
    logic [FW_W-1:0]  w_lim, w;
    logic [FH_W-1:0]  h_lim, h;
    logic             erp;

    assign w_lim = (r_frame_width > MAX_WIDTH) ? MAX_WIDTH : r_frame_width;
    assign h_lim = (r_frame_height > MAX_HEIGHT) ? MAX_HEIGHT : r_frame_height;
    assign w     = (r_in.plane != '0) ? (w_lim >> 1) : w_lim;
    assign h     = (r_in.plane != '0) ? (h_lim >> 1) : h_lim;
    assign erp   = (r_format == FMT_ERP);

    // face boundary tests: i < floor(a*w/b) is b*(i+1) <= a*w
    logic [16:0] wi, hj, ii, jj;
    logic c_i2, c_i3, c_i23, c_i4, c_i43, c_i6, c_i65;
    logic c_j2, c_j3, c_j23, c_j6, c_j65;

    assign wi = 17'(w);
    assign hj = 17'(h);
    assign ii = 17'(r_in.col) + 17'd1;
    assign jj = 17'(r_in.row) + 17'd1;

    assign c_i2  = (17'd2 * ii) <= wi;
    assign c_i3  = (17'd3 * ii) <= wi;
    assign c_i23 = (17'd3 * ii) <= (17'd2 * wi);
    assign c_i4  = (17'd4 * ii) <= wi;
    assign c_i43 = (17'd4 * ii) <= (17'd3 * wi);
    assign c_i6  = (17'd6 * ii) <= wi;
    assign c_i65 = (17'd6 * ii) <= (17'd5 * wi);
    assign c_j2  = (17'd2 * jj) <= hj;
    assign c_j3  = (17'd3 * jj) <= hj;
    assign c_j23 = (17'd3 * jj) <= (17'd2 * hj);
    assign c_j6  = (17'd6 * jj) <= hj;
    assign c_j65 = (17'd6 * jj) <= (17'd5 * hj);

    logic [3:0] n_ci_k, n_cj_k;
    t_div_sel   n_ci_m, n_cj_m, n_r_m;
    logic       n_r_h, n_blank;

    always_comb begin
        n_ci_k  = 4'd1;
        n_ci_m  = DIV_BY2;
        n_cj_k  = 4'd1;
        n_cj_m  = DIV_BY2;
        n_r_h   = 1'b0;
        n_r_m   = DIV_BY2;
        n_blank = 1'b0;
        unique case (r_format)
            FMT_ERP: begin
                n_blank = 1'b0;
            end
            FMT_CMP_3X2: begin
                n_ci_k = c_i3 ? 4'd1 : (c_i23 ? 4'd3 : 4'd5);
                n_ci_m = DIV_BY6;
                n_cj_k = c_j2 ? 4'd1 : 4'd3;
                n_cj_m = DIV_BY4;
                n_r_h  = 1'b1;
                n_r_m  = DIV_BY4;
            end
            FMT_CMP_2X3: begin
                n_ci_k = c_i2 ? 4'd1 : 4'd3;
                n_ci_m = DIV_BY4;
                n_cj_k = c_j3 ? 4'd1 : (c_j23 ? 4'd3 : 4'd5);
                n_cj_m = DIV_BY6;
                n_r_m  = DIV_BY4;
            end
            FMT_CMP_6X1: begin
                n_ci_k = c_i6 ? 4'd1 : c_i3 ? 4'd3 : c_i2 ? 4'd5 :
                         c_i23 ? 4'd7 : c_i65 ? 4'd9 : 4'd11;
                n_ci_m = DIV_BY12;
                n_r_h  = 1'b1;
            end
            FMT_CMP_1X6: begin
                n_cj_k = c_j6 ? 4'd1 : c_j3 ? 4'd3 : c_j2 ? 4'd5 :
                         c_j23 ? 4'd7 : c_j65 ? 4'd9 : 4'd11;
                n_cj_m = DIV_BY12;
            end
            FMT_CMP_T: begin
                n_r_m = DIV_BY8;
                if (c_i4) begin
                    n_ci_m = DIV_BY8;
                    n_cj_k = c_j3 ? 4'd1 : (c_j23 ? 4'd3 : 4'd5);
                    n_cj_m = DIV_BY6;
                end else if (!c_j3 && c_j23) begin
                    n_ci_k = c_i2 ? 4'd3 : (c_i43 ? 4'd5 : 4'd7);
                    n_ci_m = DIV_BY8;
                end else begin
                    n_blank = 1'b1;
                end
            end
            default: begin
                n_blank = 1'b1;
            end
        endcase
    end

    // equirectangular row distance from the equator
    logic signed [15:0] e_row;
    logic [15:0]        e_abs;
    assign e_row = $signed({3'b0, r_in.row, 1'b1}) - $signed({3'b0, h[FH_W-1:1], 1'b0});
    assign e_abs = e_row[15] ? 16'(-e_row) : 16'(e_row);

    // cube distances from the face centre
    logic signed [15:0] di, dj;
    logic [14:0]        adi, adj;
    logic [27:0]        rsq;
    assign di  = $signed({2'b0, r_in.col, 1'b1}) - $signed({1'b0, r_ci, 1'b0});
    assign dj  = $signed({3'b0, r_in.row, 1'b1}) - $signed({1'b0, r_cj, 1'b0});
    assign adi = di[15] ? 15'(-di) : 15'(di);
    assign adj = dj[15] ? 15'(-dj) : 15'(dj);
    assign rsq = {14'b0, r_rad} * {14'b0, r_rad};

    logic [31:0] s_sum;
    assign s_sum = {2'b0, r_di2} + {2'b0, r_dj2} + {4'b0, r_rr};

    // divider step
    logic [32:0] d_t;
    logic        d_ge;
    logic [32:0] d_sub;
    assign d_t   = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign d_ge  = d_t >= {1'b0, r_div};
    assign d_sub = d_t - {1'b0, r_div};

    // square root step
    logic [61:0] q_sum;
    logic        q_ge;
    assign q_sum = r_sres + {1'b0, r_sbit};
    assign q_ge  = {1'b0, r_sv} >= q_sum;

    // shared multiplier
    logic [SAMPLE_W-1:0] diff;
    logic [31:0]         mul_a, mul_b;
    assign diff = (r_in.orig_sample >= r_in.recon_sample) ?
                  (r_in.orig_sample - r_in.recon_sample) :
                  (r_in.recon_sample - r_in.orig_sample);

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_UU: begin
                mul_a = {2'b0, r_q[29:0]};
                mul_b = {2'b0, r_q[29:0]};
            end
            MUL_ZT: begin
                mul_a = {2'b0, r_z};
                mul_b = {1'b0, r_t};
            end
            MUL_XS: begin
                mul_a = {1'b0, r_q};
                mul_b = {1'b0, r_sres[30:0]};
            end
            MUL_DD: begin
                mul_a = 32'(diff);
                mul_b = 32'(diff);
            end
            MUL_PW: begin
                mul_a = r_prod[31:0];
                mul_b = 32'(r_weight);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // cosine tail
    logic [31:0]   p_s;
    logic [30:0]   cos_rem;
    logic [WW-1:0] cos_w;
    assign p_s     = r_prod[61:30];
    assign cos_rem = Q30_ONE - p_s[30:0];
    assign cos_w   = (p_s >= {1'b0, Q30_ONE}) ? '0 : cos_rem[30 -: WW];

    // accumulators with saturation
    logic [ERR_W:0]  e_sum;
    logic [WSUM_W:0] w_sum;
    assign e_sum = {1'b0, r_err} + {1'b0, r_prod[ERR_W-1:0]};
    assign w_sum = {1'b0, r_wacc} + (WSUM_W + 1)'(r_weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format       <= RST_FORMAT;
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
            r_err          <= '0;
            r_wacc         <= '0;
            r_out_valid    <= 1'b0;
            r_cnt          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FORMAT: r_format       <= i_cfg_data[FMT_W-1:0];
                    REG_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                    REG_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                    default:    r_format       <= r_format;
                endcase
            end
            if (i_cmd.div_load || i_cmd.sqrt_load || i_cmd.z_set) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step || i_cmd.sqrt_step ||
                         (i_cmd.poly_add && r_cnt != POLY_STEPS)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.emit) begin
                r_err       <= '0;
                r_wacc      <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (i_cmd.acc) begin
                    r_err  <= e_sum[ERR_W] ? '1 : e_sum[ERR_W-1:0];
                    r_wacc <= w_sum[WSUM_W] ? '1 : w_sum[WSUM_W-1:0];
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.face) begin
            r_ci_k  <= n_ci_k;
            r_ci_m  <= n_ci_m;
            r_cj_k  <= n_cj_k;
            r_cj_m  <= n_cj_m;
            r_r_h   <= n_r_h;
            r_r_m   <= n_r_m;
            r_blank <= n_blank;
        end
        if (i_cmd.center) begin
            r_ci  <= scale_div(r_ci_k, w, r_ci_m);
            r_cj  <= scale_div(r_cj_k, {1'b0, h}, r_cj_m);
            r_rad <= scale_div(4'd1, r_r_h ? {1'b0, h} : w, r_r_m);
            r_a   <= e_abs[CRD_W-1:0];
        end
        if (i_cmd.square) begin
            r_di2  <= {15'b0, adi} * {15'b0, adi};
            r_dj2  <= {15'b0, adj} * {15'b0, adj};
            r_rr   <= {rsq[25:0], 2'b00};
            r_zero <= erp ? ((h == '0) || (r_a >= {1'b0, h}))
                          : (r_blank || (r_rad == '0));
        end
        if (i_cmd.div_load) begin
            r_rem <= erp ? {18'b0, r_a} : {4'b0, r_rr};
            r_div <= erp ? {19'b0, h} : s_sum;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= d_ge ? d_sub[31:0] : d_t[31:0];
            r_q   <= {r_q[29:0], d_ge};
        end
        if (i_cmd.sqrt_load) begin
            r_sv   <= {r_q, 30'b0};
            r_sres <= '0;
            r_sbit <= 61'(1) << 60;
        end else if (i_cmd.sqrt_step) begin
            if (q_ge) begin
                r_sv   <= r_sv - q_sum[60:0];
                r_sres <= (r_sres >> 1) + {1'b0, r_sbit};
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.z_set) begin
            r_z <= r_prod[59:30];
            r_t <= COS_C6;
        end
        if (i_cmd.poly_add) begin
            if (r_cnt != POLY_STEPS) begin
                r_t <= cos_coef(r_cnt[2:0]) - r_prod[60:30];
            end else begin
                r_weight <= cos_w;
            end
        end
        if (i_cmd.w_cube) begin
            r_weight <= r_prod[60 -: WW];
        end
        if (i_cmd.w_zero) begin
            r_weight <= '0;
        end
        if (i_cmd.emit) begin
            r_out.weighted_sq_error_sum <= r_err;
            r_out.weight_sum            <= r_wacc;
            r_out.done_plane            <= r_in.plane;
        end
    end

    assign o_status.erp       = erp;
    assign o_status.zero      = r_zero;
    assign o_status.step_last = (r_cnt == STEP_LAST);
    assign o_status.poly_done = (r_cnt == POLY_STEPS);
    assign o_status.last      = r_in.last_of_plane;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc |-> (r_weight <= W_ONE))
        else $error("weight above one");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_err == '0) && (r_wacc == '0) && r_out_valid)
        else $error("sums not cleared after result");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted sphere error accumulator. Samples are
// pushed through the valid/ready input under several projections and frame
// sizes; a behavioral model computes the expected plane sums, which a
// scoreboard compares against every output transfer.
// ----------------------------------------------------------------------------
module tb_top;
    import wsea_pkg::*;

    localparam longint ERR_ALL  = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint WSUM_ALL = 64'hFF_FFFF_FFFF;
    localparam int     MAX_CYC  = 4000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_item;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_item;

    weighted_sphere_error_accumulator_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    class plane_sum_board;
        t_out_item sums_q[$];
        int        fails;
        logic [2:0]  fmt;
        logic [13:0] fw;
        logic [12:0] fh;
        longint unsigned err_acc;
        longint unsigned wt_acc;

        function void clear();
            fmt = RST_FORMAT;
            fw = RST_WIDTH;
            fh = RST_HEIGHT;
            err_acc = 0;
            wt_acc = 0;
            fails = 0;
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function longint unsigned erp_wt(longint j, longint h);
            longint n, a;
            longint unsigned u, z, t, s;
            if (h <= 0) return 0;
            n = 2 * j + 1 - 2 * (h / 2);
            a = n < 0 ? -n : n;
            if (a >= h) return 0;
            u = (longint'(a) << 30) / h;
            z = (u * u) >> 30;
            t = COS_C6;
            t = COS_C5 - ((z * t) >> 30);
            t = COS_C4 - ((z * t) >> 30);
            t = COS_C3 - ((z * t) >> 30);
            t = COS_C2 - ((z * t) >> 30);
            t = COS_C1 - ((z * t) >> 30);
            s = (z * t) >> 30;
            if (s >= Q30_ONE) return 0;
            return (Q30_ONE - s) >> 14;
        endfunction

        function longint unsigned face_wt(longint i, longint j, longint ci, longint cj,
                                          longint r);
            longint di, dj;
            longint unsigned rr, ss, x, s;
            di = 2 * i + 1 - 2 * ci;
            dj = 2 * j + 1 - 2 * cj;
            rr = 4 * r * r;
            ss = rr + di * di + dj * dj;
            if (rr == 0) return 0;
            x = (rr << 30) / ss;
            s = isqrt(x << 30);
            return (x * s) >> 44;
        endfunction

        function longint unsigned sphere_wt(longint i, longint j, longint w, longint h);
            longint ci, cj;
            case (fmt)
                FMT_ERP: return erp_wt(j, h);
                FMT_CMP_3X2: begin
                    ci = (i < w / 3) ? w / 6 : (i < 2 * w / 3) ? w / 2 : 5 * w / 6;
                    cj = (j < h / 2) ? h / 4 : 3 * h / 4;
                    return face_wt(i, j, ci, cj, h / 4);
                end
                FMT_CMP_2X3: begin
                    ci = (i < w / 2) ? w / 4 : 3 * w / 4;
                    cj = (j < h / 3) ? h / 6 : (j < 2 * h / 3) ? h / 2 : 5 * h / 6;
                    return face_wt(i, j, ci, cj, w / 4);
                end
                FMT_CMP_6X1: begin
                    ci = (i < w / 6) ? w / 12 : (i < w / 3) ? w / 4
                       : (i < w / 2) ? 5 * w / 12 : (i < 2 * w / 3) ? 7 * w / 12
                       : (i < 5 * w / 6) ? 3 * w / 4 : 11 * w / 12;
                    return face_wt(i, j, ci, h / 2, h / 2);
                end
                FMT_CMP_1X6: begin
                    cj = (j < h / 6) ? h / 12 : (j < h / 3) ? h / 4
                       : (j < h / 2) ? 5 * h / 12 : (j < 2 * h / 3) ? 7 * h / 12
                       : (j < 5 * h / 6) ? 3 * h / 4 : 11 * h / 12;
                    return face_wt(i, j, w / 2, cj, w / 2);
                end
                FMT_CMP_T: begin
                    if (i < w / 4) begin
                        cj = (j < h / 3) ? h / 6 : (j < 2 * h / 3) ? h / 2 : 5 * h / 6;
                        return face_wt(i, j, w / 8, cj, w / 8);
                    end
                    if (j >= h / 3 && j < 2 * h / 3) begin
                        ci = (i < w / 2) ? 3 * w / 8 : (i < 3 * w / 4) ? 5 * w / 8
                           : 7 * w / 8;
                        return face_wt(i, j, ci, h / 2, w / 8);
                    end
                    return 0;
                end
                default: return 0;
            endcase
        endfunction

        function void note_sample(t_in_item it);
            longint w, h;
            longint unsigned wt, d;
            t_out_item o;
            w = fw > MAX_WIDTH ? MAX_WIDTH : fw;
            h = fh > MAX_HEIGHT ? MAX_HEIGHT : fh;
            if (it.plane != 0) begin
                w = w / 2;
                h = h / 2;
            end
            wt = sphere_wt(it.col, it.row, w, h);
            d = it.orig_sample >= it.recon_sample ? it.orig_sample - it.recon_sample
                                                  : it.recon_sample - it.orig_sample;
            err_acc += d * d * wt;
            if (err_acc > ERR_ALL) err_acc = ERR_ALL;
            wt_acc += wt;
            if (wt_acc > WSUM_ALL) wt_acc = WSUM_ALL;
            if (it.last_of_plane) begin
                o.weighted_sq_error_sum = err_acc[ERR_W-1:0];
                o.weight_sum = wt_acc[WSUM_W-1:0];
                o.done_plane = it.plane;
                sums_q.push_back(o);
                err_acc = 0;
                wt_acc = 0;
            end
        endfunction

        function void check_sums(t_out_item got);
            t_out_item e;
            if (sums_q.size() == 0) begin
                $error("unexpected output transfer %h", got);
                fails++;
                return;
            end
            e = sums_q.pop_front();
            if (got.weighted_sq_error_sum !== e.weighted_sq_error_sum) begin
                $error("weighted_sq_error_sum exp %0d got %0d",
                       e.weighted_sq_error_sum, got.weighted_sq_error_sum);
                fails++;
            end
            if (got.weight_sum !== e.weight_sum) begin
                $error("weight_sum exp %0d got %0d", e.weight_sum, got.weight_sum);
                fails++;
            end
            if (got.done_plane !== e.done_plane) begin
                $error("done_plane exp %0d got %0d", e.done_plane, got.done_plane);
                fails++;
            end
        endfunction
    endclass

    plane_sum_board board;
    int  send_idle;
    int  recv_idle;
    int  hold_off;
    int  cyc;

    initial begin
        board = new();
        board.clear();
    end

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) board.check_sums(o_out_item);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > MAX_CYC) begin
            $display("weighted_sphere_error_accumulator_unit regression: fail");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FORMAT: board.fmt = val[2:0];
            REG_WIDTH:  board.fw = val[13:0];
            default:    board.fh = val[12:0];
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.sums_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_frame(logic [2:0] f, int w, int h);
        drain();
        cfg_write(REG_FORMAT, CFG_W'(f));
        cfg_write(REG_WIDTH, CFG_W'(w));
        cfg_write(REG_HEIGHT, CFG_W'(h));
    endtask

    task automatic send(t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_sample(it);
    endtask

    function automatic t_in_item rand_item(int w, int h, int last_pct);
        t_in_item it;
        int pw, ph;
        it.plane = PLANE_W'($urandom_range(3));
        pw = it.plane != 0 ? w / 2 : w;
        ph = it.plane != 0 ? h / 2 : h;
        it.orig_sample = SAMPLE_W'($urandom);
        it.recon_sample = ($urandom_range(3) == 0) ? SAMPLE_W'($urandom)
                        : SAMPLE_W'(32'(it.orig_sample) + $urandom_range(16) - 8);
        if ($urandom_range(9) == 0) begin
            it.col = COL_W'($urandom);
            it.row = ROW_W'($urandom);
        end else begin
            it.col = COL_W'($urandom_range(pw > 0 ? pw - 1 : 0));
            it.row = ROW_W'($urandom_range(ph > 0 ? ph - 1 : 0));
        end
        it.last_of_plane = ($urandom_range(99) < last_pct);
        return it;
    endfunction

    task automatic rand_block(int n, int last_pct);
        for (int k = 0; k < n; k++)
            send(rand_item(board.fw, board.fh, last_pct));
        send(rand_item(board.fw, board.fh, 100));
    endtask

    initial begin
        t_in_item it;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        hold_off = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset frame, extremes and corner positions
        it = '{10'd1023, 10'd0, 13'd0, 12'd539, 2'd0, 1'b0};
        send(it);
        it = '{10'd0, 10'd1023, 13'd8191, 12'd4095, 2'd3, 1'b1};
        send(it);
        it = '{10'd1023, 10'd1023, 13'd100, 12'd0, 2'd1, 1'b1};
        send(it);
        for (int f = 0; f < 8; f++) begin
            set_frame(3'(f), 24, 12);
            it = '{10'd5, 10'd0, 13'd11, 12'd2, 2'd0, 1'b0};
            send(it);
            it = '{10'd7, 10'd900, 13'd12, 12'd6, 2'd2, 1'b1};
            send(it);
        end
        // zero-size faces and tiny frame, oversize frame saturation
        set_frame(FMT_CMP_T, 2, 2);
        it = '{10'd3, 10'd0, 13'd0, 12'd0, 2'd1, 1'b1};
        send(it);
        set_frame(FMT_ERP, 16383, 8191);
        it = '{10'd1023, 10'd0, 13'd4000, 12'd2048, 2'd0, 1'b1};
        send(it);

        // random phases over several frame settings and idling profiles
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = ph == 0 ? 16 : ph == 1 ? 72 : 0;
            recv_idle = ph == 0 ? 72 : ph == 1 ? 16 : 0;
            for (int s = 0; s < 6; s++) begin
                set_frame(3'(s), 2 + $urandom_range(62), 2 + $urandom_range(40));
                rand_block(20, 15);
            end
        end
        set_frame(FMT_CMP_3X2, 8192, 4096);
        rand_block(10, 30);
        set_frame(FMT_CMP_6X1, 96, 16);

        // long receiver stall while closing samples keep coming
        hold_off = 400;
        for (int k = 0; k < 6; k++) send(rand_item(board.fw, board.fh, 100));
        drain();
        rand_block(20, 20);

        drain();
        if (board.fails == 0) begin
            $display("weighted_sphere_error_accumulator_unit regression: pass");
        end else begin
            $display("weighted_sphere_error_accumulator_unit regression: fail");
        end
        $finish;
    end

endmodule
